// File: design/ip_flood_blacklist_table_top_macros.svh
// Assertion macros used by the top-level design file.
`ifndef IP_FLOOD_BLACKLIST_TABLE_TOP_MACROS_SVH
`define IP_FLOOD_BLACKLIST_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IPFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ipfb_pkg.sv
package ipfb_pkg;

    localparam int LIST_ENTRIES = 64;
    localparam int RATE_ENTRIES = 64;
    localparam int SCAN_N = (LIST_ENTRIES > RATE_ENTRIES) ? LIST_ENTRIES : RATE_ENTRIES;
    localparam int LIDX_W = $clog2(LIST_ENTRIES);
    localparam int RIDX_W = $clog2(RATE_ENTRIES);
    localparam int SCAN_W = $clog2(SCAN_N + 1);
    localparam int CNT_W = $clog2(LIST_ENTRIES + 1);

    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [15:0] THR_RESET = 16'd100;
    localparam logic [23:0] BAN_RESET = 24'd300;

    typedef enum logic [2:0] {
        CMD_CHECK  = 3'd0,
        CMD_QUERY  = 3'd1,
        CMD_ADD    = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_SWEEP  = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_t;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_BAN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    // Read addresses into both tables.
    typedef struct packed {
        logic [LIDX_W-1:0] lidx;
        logic [RIDX_W-1:0] ridx;
    } tbl_rd_t;

    // Registered read data from both tables.
    typedef struct packed {
        logic [31:0] laddr;
        logic [32:0] lexpiry;
        logic [31:0] raddr;
        logic [31:0] rsecond;
        logic [16:0] rcount;
    } tbl_rdata_t;

    // One write into each table.
    typedef struct packed {
        logic              list_we;
        logic [LIDX_W-1:0] lidx;
        logic [31:0]       laddr;
        logic [32:0]       lexpiry;
        logic              rate_we;
        logic [RIDX_W-1:0] ridx;
        logic [31:0]       raddr;
        logic [31:0]       rsecond;
        logic [16:0]       rcount;
    } tbl_wr_t;

endpackage

// File: design/ipfb_req_if.sv
interface ipfb_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] source_addr;
    logic [31:0] now_sec;

    modport source (output valid, output command, output source_addr, output now_sec,
                    input ready);
    modport sink (input valid, input command, input source_addr, input now_sec,
                  output ready);
endinterface

// File: design/ipfb_rsp_if.sv
interface ipfb_rsp_if;
    logic        valid;
    logic        ready;
    logic        blocked;
    logic        dirty_flag;
    logic        table_full;
    logic [6:0]  listed_count;
    logic [31:0] drop_total;

    modport source (output valid, output blocked, output dirty_flag, output table_full,
                    output listed_count, output drop_total, input ready);
    modport sink (input valid, input blocked, input dirty_flag, input table_full,
                  input listed_count, input drop_total, output ready);
endinterface

// File: design/ipfb_tables.sv
module ipfb_tables
    import ipfb_pkg::*;
(
    input  logic       clk,
    input  tbl_rd_t    rd,
    input  tbl_wr_t    wr,
    output tbl_rdata_t rdata
);

    logic [31:0] list_addr_mem   [LIST_ENTRIES];
    logic [32:0] list_expiry_mem [LIST_ENTRIES];
    logic [31:0] rate_addr_mem   [RATE_ENTRIES];
    logic [31:0] rate_second_mem [RATE_ENTRIES];
    logic [16:0] rate_count_mem  [RATE_ENTRIES];

    // Blacklist and rate memories: one write and one registered read each per cycle.
    always_ff @(posedge clk)
    begin
        if (wr.list_we)
        begin
            list_addr_mem[wr.lidx]   <= wr.laddr;
            list_expiry_mem[wr.lidx] <= wr.lexpiry;
        end
        if (wr.rate_we)
        begin
            rate_addr_mem[wr.ridx]   <= wr.raddr;
            rate_second_mem[wr.ridx] <= wr.rsecond;
            rate_count_mem[wr.ridx]  <= wr.rcount;
        end
        rdata.laddr   <= list_addr_mem[rd.lidx];
        rdata.lexpiry <= list_expiry_mem[rd.lidx];
        rdata.raddr   <= rate_addr_mem[rd.ridx];
        rdata.rsecond <= rate_second_mem[rd.ridx];
        rdata.rcount  <= rate_count_mem[rd.ridx];
    end

endmodule

// File: design/ip_flood_blacklist_table_top.sv
// Per-source rate limiter with an expiring blacklist. Each request transfer is
// handled alone: after acceptance the block scans the blacklist and rate tables
// together, one entry per cycle through their single read ports, then performs
// the update and presents the result, waiting there while an earlier result is
// still not taken. A new request is accepted while the previous result still
// waits on the response channel. Valid bits live in flip-flops, so no clearing
// pass follows reset.
`include "ip_flood_blacklist_table_top_macros.svh"

module ip_flood_blacklist_table_top
    import ipfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ipfb_req_if.sink    req,
    ipfb_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_wdata
);

    state_t state_reg, state_next;

    logic [15:0] thr_reg;
    logic [23:0] ban_reg;

    logic [2:0]  cmd_reg;
    logic [31:0] addr_reg;
    logic [31:0] now_reg;

    logic [SCAN_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [SCAN_W-1:0] proc_idx_reg, proc_idx_next;
    logic              pend_reg, pend_next;

    logic [LIST_ENTRIES-1:0] list_valid_reg, list_valid_next;
    logic [RATE_ENTRIES-1:0] rate_valid_reg, rate_valid_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    dirty_reg, dirty_next;
    logic [31:0]             drop_reg, drop_next;

    // Scan findings.
    logic              lm_found_reg, lm_found_next;
    logic [LIDX_W-1:0] lm_idx_reg, lm_idx_next;
    logic [32:0]       lm_exp_reg, lm_exp_next;
    logic              lf_found_reg, lf_found_next;
    logic [LIDX_W-1:0] lf_idx_reg, lf_idx_next;
    logic              ls_found_reg, ls_found_next;
    logic [LIDX_W-1:0] ls_idx_reg, ls_idx_next;
    logic              rm_found_reg, rm_found_next;
    logic [RIDX_W-1:0] rm_idx_reg, rm_idx_next;
    logic [31:0]       rm_sec_reg, rm_sec_next;
    logic [16:0]       rm_cnt_reg, rm_cnt_next;
    logic              rf_found_reg, rf_found_next;
    logic [RIDX_W-1:0] rf_idx_reg, rf_idx_next;
    logic              rs_found_reg, rs_found_next;
    logic [RIDX_W-1:0] rs_idx_reg, rs_idx_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic        blocked_reg, blocked_next;
    logic        full_reg, full_next;
    logic [6:0]  listed_reg, listed_next;
    logic        dirty_out_reg, dirty_out_next;

    tbl_rd_t    tbl_rd;
    tbl_wr_t    tbl_wr;
    tbl_rdata_t tbl_rdata;

    logic              req_fire;
    logic              upd_go;
    logic [LIDX_W-1:0] pl_idx;
    logic [RIDX_W-1:0] pr_idx;
    logic              l_valid;
    logic              l_expired;
    logic              r_valid;
    logic              ins_ok;
    logic [LIDX_W-1:0] ins_idx;
    logic              ins_new;
    logic [RIDX_W-1:0] rk_idx;
    logic              rk_ok;
    logic [16:0]       cnt0;
    logic [16:0]       cnt1;
    logic [32:0]       expiry_new;
    logic [32:0]       drop_sum33;
    logic [31:0]       drop_sat;
    logic [31:0]       count_ext;

    assign req_fire = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign upd_go = (state_reg == ST_UPD) && (!out_valid_reg || rsp.ready);

    // The dirty flag is held with the result, since a sweep of the next item
    // may change the live flag while the result waits.
    assign rsp.valid        = out_valid_reg;
    assign rsp.blocked      = blocked_reg;
    assign rsp.dirty_flag   = dirty_out_reg;
    assign rsp.table_full   = full_reg;
    assign rsp.listed_count = listed_reg;
    assign rsp.drop_total   = drop_reg;

    ipfb_tables u_tables (
        .clk   (clk),
        .rd    (tbl_rd),
        .wr    (tbl_wr),
        .rdata (tbl_rdata)
    );

    // Read addresses follow the scan counter.
    assign tbl_rd.lidx = scan_cnt_reg[LIDX_W-1:0];
    assign tbl_rd.ridx = scan_cnt_reg[RIDX_W-1:0];

    assign pl_idx = proc_idx_reg[LIDX_W-1:0];
    assign pr_idx = proc_idx_reg[RIDX_W-1:0];
    assign l_valid = list_valid_reg[pl_idx];
    assign r_valid = rate_valid_reg[pr_idx];
    assign l_expired = {1'b0, now_reg} > tbl_rdata.lexpiry;

    // Insert slot choice: same address, lowest free, lowest expired.
    always_comb
    begin
        ins_ok = 1'b1;
        ins_new = 1'b0;
        ins_idx = lm_idx_reg;
        if (lm_found_reg)
        begin
            ins_idx = lm_idx_reg;
        end
        else if (lf_found_reg)
        begin
            ins_idx = lf_idx_reg;
            ins_new = 1'b1;
        end
        else if (ls_found_reg)
        begin
            ins_idx = ls_idx_reg;
        end
        else
        begin
            ins_ok = 1'b0;
        end
    end

    // Rate slot choice: same address, lowest free, lowest of another second.
    always_comb
    begin
        rk_ok = 1'b1;
        rk_idx = rm_idx_reg;
        if (rm_found_reg)
        begin
            rk_idx = rm_idx_reg;
        end
        else if (rf_found_reg)
        begin
            rk_idx = rf_idx_reg;
        end
        else if (rs_found_reg)
        begin
            rk_idx = rs_idx_reg;
        end
        else
        begin
            rk_ok = 1'b0;
        end
    end

    // Packet count, ban expiry and drop total arithmetic.
    assign cnt0 = (rm_found_reg && (rm_sec_reg == now_reg)) ? rm_cnt_reg : 17'd0;
    assign cnt1 = (cnt0 < COUNT_MAX) ? cnt0 + 17'd1 : cnt0;
    assign expiry_new = {1'b0, now_reg} + {9'd0, ban_reg};
    assign drop_sum33 = {1'b0, drop_reg} + {17'd0, thr_reg};
    assign drop_sat = drop_sum33[32] ? 32'hFFFF_FFFF : drop_sum33[31:0];

    // Main sequencer: scan, then update and result.
    always_comb
    begin
        state_next = state_reg;
        scan_cnt_next = scan_cnt_reg;
        proc_idx_next = proc_idx_reg;
        pend_next = 1'b0;
        list_valid_next = list_valid_reg;
        rate_valid_next = rate_valid_reg;
        count_next = count_reg;
        dirty_next = dirty_reg;
        drop_next = drop_reg;
        lm_found_next = lm_found_reg;
        lm_idx_next = lm_idx_reg;
        lm_exp_next = lm_exp_reg;
        lf_found_next = lf_found_reg;
        lf_idx_next = lf_idx_reg;
        ls_found_next = ls_found_reg;
        ls_idx_next = ls_idx_reg;
        rm_found_next = rm_found_reg;
        rm_idx_next = rm_idx_reg;
        rm_sec_next = rm_sec_reg;
        rm_cnt_next = rm_cnt_reg;
        rf_found_next = rf_found_reg;
        rf_idx_next = rf_idx_reg;
        rs_found_next = rs_found_reg;
        rs_idx_next = rs_idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        blocked_next = blocked_reg;
        full_next = full_reg;
        listed_next = listed_reg;
        dirty_out_next = dirty_out_reg;
        tbl_wr = '0;
        count_ext = 32'(count_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_SCAN;
                    scan_cnt_next = '0;
                    lm_found_next = 1'b0;
                    lf_found_next = 1'b0;
                    ls_found_next = 1'b0;
                    rm_found_next = 1'b0;
                    rf_found_next = 1'b0;
                    rs_found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // Issue the next read and retire the entry read last cycle.
                if (scan_cnt_reg < SCAN_W'(SCAN_N))
                begin
                    pend_next = 1'b1;
                    proc_idx_next = scan_cnt_reg;
                    scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                end
                else
                begin
                    state_next = ST_UPD;
                end
                if (pend_reg && (proc_idx_reg < SCAN_W'(LIST_ENTRIES)))
                begin
                    if (l_valid && (tbl_rdata.laddr == addr_reg) && !lm_found_reg)
                    begin
                        lm_found_next = 1'b1;
                        lm_idx_next = pl_idx;
                        lm_exp_next = tbl_rdata.lexpiry;
                    end
                    if (!l_valid && !lf_found_reg)
                    begin
                        lf_found_next = 1'b1;
                        lf_idx_next = pl_idx;
                    end
                    if (l_expired && !ls_found_reg)
                    begin
                        ls_found_next = 1'b1;
                        ls_idx_next = pl_idx;
                    end
                    if ((cmd_reg == CMD_SWEEP) && l_valid && l_expired)
                    begin
                        list_valid_next[pl_idx] = 1'b0;
                        dirty_next = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                if (pend_reg && (proc_idx_reg < SCAN_W'(RATE_ENTRIES)))
                begin
                    if (r_valid && (tbl_rdata.raddr == addr_reg) && !rm_found_reg)
                    begin
                        rm_found_next = 1'b1;
                        rm_idx_next = pr_idx;
                        rm_sec_next = tbl_rdata.rsecond;
                        rm_cnt_next = tbl_rdata.rcount;
                    end
                    if (!r_valid && !rf_found_reg)
                    begin
                        rf_found_next = 1'b1;
                        rf_idx_next = pr_idx;
                    end
                    if ((tbl_rdata.rsecond != now_reg) && !rs_found_reg)
                    begin
                        rs_found_next = 1'b1;
                        rs_idx_next = pr_idx;
                    end
                end
            end
            ST_UPD:
            begin
                if (upd_go)
                begin
                    blocked_next = 1'b0;
                    full_next = 1'b0;
                    tbl_wr.lidx = ins_idx;
                    tbl_wr.laddr = addr_reg;
                    tbl_wr.lexpiry = expiry_new;
                    tbl_wr.ridx = rk_idx;
                    tbl_wr.raddr = addr_reg;
                    tbl_wr.rsecond = now_reg;
                    tbl_wr.rcount = cnt1;
                    case (cmd_reg)
                        CMD_CHECK:
                        begin
                            if (lm_found_reg)
                            begin
                                blocked_next = 1'b1;
                            end
                            else if (!rk_ok)
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                tbl_wr.rate_we = 1'b1;
                                rate_valid_next[rk_idx] = 1'b1;
                                if (cnt1 > {1'b0, thr_reg})
                                begin
                                    tbl_wr.rcount = 17'd0;
                                    drop_next = drop_sat;
                                    blocked_next = 1'b1;
                                    if (ins_ok)
                                    begin
                                        tbl_wr.list_we = 1'b1;
                                        list_valid_next[ins_idx] = 1'b1;
                                        dirty_next = 1'b1;
                                        if (ins_new)
                                        begin
                                            count_next = count_reg + CNT_W'(1);
                                        end
                                    end
                                    else
                                    begin
                                        full_next = 1'b1;
                                    end
                                end
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (lm_found_reg)
                            begin
                                if ({1'b0, now_reg} > lm_exp_reg)
                                begin
                                    list_valid_next[lm_idx_reg] = 1'b0;
                                    dirty_next = 1'b1;
                                    count_next = count_reg - CNT_W'(1);
                                end
                                else
                                begin
                                    blocked_next = 1'b1;
                                end
                            end
                        end
                        CMD_ADD:
                        begin
                            if (ins_ok)
                            begin
                                tbl_wr.list_we = 1'b1;
                                list_valid_next[ins_idx] = 1'b1;
                                dirty_next = 1'b1;
                                blocked_next = 1'b1;
                                if (ins_new)
                                begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (lm_found_reg)
                            begin
                                list_valid_next[lm_idx_reg] = 1'b0;
                                dirty_next = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            dirty_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                    count_ext = 32'(count_next);
                    listed_next = (count_ext > 32'd127) ? 7'd127 : count_ext[6:0];
                    dirty_out_next = dirty_next;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_cnt_reg <= '0;
            pend_reg <= 1'b0;
            list_valid_reg <= '0;
            rate_valid_reg <= '0;
            count_reg <= '0;
            dirty_reg <= 1'b0;
            drop_reg <= '0;
            out_valid_reg <= 1'b0;
            thr_reg <= THR_RESET;
            ban_reg <= BAN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            pend_reg <= pend_next;
            list_valid_reg <= list_valid_next;
            rate_valid_reg <= rate_valid_next;
            count_reg <= count_next;
            dirty_reg <= dirty_next;
            drop_reg <= drop_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == CFG_THRESHOLD))
            begin
                thr_reg <= cfg_wdata[15:0];
            end
            if (cfg_we && (cfg_index == CFG_BAN))
            begin
                ban_reg <= cfg_wdata;
            end
        end
    end

    // Payload and scan findings.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg <= req.command;
            addr_reg <= req.source_addr;
            now_reg <= req.now_sec;
        end
        proc_idx_reg <= proc_idx_next;
        lm_found_reg <= lm_found_next;
        lm_idx_reg <= lm_idx_next;
        lm_exp_reg <= lm_exp_next;
        lf_found_reg <= lf_found_next;
        lf_idx_reg <= lf_idx_next;
        ls_found_reg <= ls_found_next;
        ls_idx_reg <= ls_idx_next;
        rm_found_reg <= rm_found_next;
        rm_idx_reg <= rm_idx_next;
        rm_sec_reg <= rm_sec_next;
        rm_cnt_reg <= rm_cnt_next;
        rf_found_reg <= rf_found_next;
        rf_idx_reg <= rf_idx_next;
        rs_found_reg <= rs_found_next;
        rs_idx_reg <= rs_idx_next;
        blocked_reg <= blocked_next;
        full_reg <= full_next;
        listed_reg <= listed_next;
        dirty_out_reg <= dirty_out_next;
    end

    // Checks on the sequencer and the entry count.
    `IPFB_ASSERT_NOW(a_count_matches, clk, rst_n, 1'b1,
        32'(count_reg) == 32'($countones(list_valid_reg)),
        "entry count differs from the number of valid bits")
    `IPFB_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, req_fire,
        (state_reg == ST_SCAN) && (scan_cnt_reg == '0) && !pend_reg,
        "accepted transfer did not start a fresh scan")
    `IPFB_ASSERT_NEXT(a_scan_ends, clk, rst_n,
        (state_reg == ST_SCAN) && (scan_cnt_reg == SCAN_W'(SCAN_N)),
        state_reg == ST_UPD, "scan did not hand over to the update")
    `IPFB_ASSERT_NEXT(a_upd_gives_result, clk, rst_n, upd_go,
        rsp.valid && (state_reg == ST_IDLE), "update did not present a result")

endmodule
